// ===== rtl/i2a_pkg.sv =====
// Package for the integer to ASCII formatter: widths, format codes and
// character constants. No dependencies.

package i2a_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int HEX_DIGITS  = (VALUE_BITS + 3) / 4;
  localparam int DEC_BITS    = 32;
  localparam int BCD_DIGITS  = 10;
  localparam int BCD_W       = BCD_DIGITS * 4;
  localparam int HEX_W       = HEX_DIGITS * 4;
  localparam int DIG_W       = (HEX_W > BCD_W) ? HEX_W : BCD_W;
  localparam int MAX_DIGITS  = (HEX_DIGITS > BCD_DIGITS) ? HEX_DIGITS : BCD_DIGITS;
  localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);
  localparam int CNT_W       = $clog2(DEC_BITS);
  localparam int LEN_W       = 5;
  localparam int CHAR_W      = 8;
  localparam int FUNC_W      = 3;
  localparam int IN_DATA_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((CHAR_W + LEN_W + 7) / 8) * 8;

  localparam logic [FUNC_W-1:0] FMT_SDEC = 3'd0;
  localparam logic [FUNC_W-1:0] FMT_UDEC = 3'd1;
  localparam logic [FUNC_W-1:0] FMT_HEXL = 3'd2;
  localparam logic [FUNC_W-1:0] FMT_HEXU = 3'd3;
  localparam logic [FUNC_W-1:0] FMT_PTR  = 3'd4;

  localparam logic [CHAR_W-1:0] ASC_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASC_UOFS  = 8'd55;
  localparam logic [CHAR_W-1:0] ASC_LOFS  = 8'd87;
  localparam logic [CHAR_W-1:0] ASC_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] ASC_X     = 8'h78;

  localparam logic [LEN_W-1:0] NIL_LEN = 5'd5;

  function automatic logic [CHAR_W-1:0] nil_char(input logic [2:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6c;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter, top level.
// Depends on i2a_pkg.
//
// Usage: one beat on the slave side carries a number (tdata) and a format
// code (tuser): 0 signed decimal, 1 unsigned decimal, 2 hex lower, 3 hex
// upper, 4 pointer ("0x" + hex, or "(nil)" for zero). Codes 5..7 are
// dropped without output. The master side then gives one beat per
// character, most significant first; each beat carries the run length
// and tlast marks the final character.
// Decimal forms go through a bit-serial double dabble converter, one
// source bit per cycle. Leading zero digits are then dropped one per
// cycle (up to 9 for decimal, HEX_DIGITS-1 for hex). Characters then
// leave at one per cycle while the receiver takes them.
// tready is high only between items; the last character may still sit in
// the output register while the next item is taken.
// A stalled receiver holds the current beat and freezes emission.
// Reset (rst, synchronous) empties the output and returns to idle.

module integer_to_ascii_formatter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [i2a_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // [63:0] value
  input  logic [i2a_pkg::FUNC_W-1:0]     s_axis_tuser,  // [2:0] func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [i2a_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [7:0] char_out, [12:8] run_length
  output logic                           m_axis_tlast   // last_char
);

  import i2a_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SKIP, ST_EMIT} state_t;

  state_t                 state;
  logic [FUNC_W-1:0]      func;
  logic                   neg;
  logic                   nil;
  logic [DEC_BITS-1:0]    src;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_next;
  logic [CNT_W-1:0]       cnt;
  logic [DIG_W-1:0]       dig;
  logic [NDIG_W-1:0]      nd;
  logic [LEN_W-1:0]       len;
  logic [LEN_W-1:0]       pos;
  logic [LEN_W-1:0]       prefix;
  logic [3:0]             nib;
  logic [CHAR_W-1:0]      ch;
  logic                   in_acc;
  logic                   out_free;
  logic                   is_digit;
  logic [DEC_BITS-1:0]    low;
  logic [VALUE_BITS-1:0]  hexval;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign low           = s_axis_tdata[DEC_BITS-1:0];
  assign hexval        = s_axis_tdata[VALUE_BITS-1:0];

  // double dabble: add 3 to each BCD digit of 5 or more, then shift
  always_comb begin
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end
    end
    bcd_next = {adj[BCD_W-2:0], src[DEC_BITS-1]};
  end

  always_comb begin
    if (neg) begin
      prefix = 5'd1;
    end else if (func == FMT_PTR) begin
      prefix = 5'd2;
    end else begin
      prefix = 5'd0;
    end
  end

  assign nib      = dig[DIG_W-1 -: 4];
  assign is_digit = (pos >= prefix);

  always_comb begin
    if (nil) begin
      ch = nil_char(pos[2:0]);
    end else if (!is_digit) begin
      if (neg) begin
        ch = ASC_MINUS;
      end else if (pos == '0) begin
        ch = ASC_ZERO;
      end else begin
        ch = ASC_X;
      end
    end else if (nib < 4'd10) begin
      ch = ASC_ZERO + CHAR_W'(nib);
    end else if (func == FMT_HEXU) begin
      ch = ASC_UOFS + CHAR_W'(nib);
    end else begin
      ch = ASC_LOFS + CHAR_W'(nib);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            func <= s_axis_tuser;
            neg  <= (s_axis_tuser == FMT_SDEC) && low[DEC_BITS-1];
            nil  <= (s_axis_tuser == FMT_PTR) && (hexval == '0);
            pos  <= '0;
            cnt  <= '0;
            bcd  <= '0;
            case (s_axis_tuser)
              FMT_SDEC: begin
                src   <= low[DEC_BITS-1] ? (~low) + 32'd1 : low;
                state <= ST_CONV;
              end
              FMT_UDEC: begin
                src   <= low;
                state <= ST_CONV;
              end
              FMT_HEXL, FMT_HEXU, FMT_PTR: begin
                dig   <= DIG_W'(hexval) << (DIG_W - HEX_W);
                nd    <= NDIG_W'(HEX_DIGITS);
                state <= ST_SKIP;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_CONV: begin
          bcd <= bcd_next;
          src <= src << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DEC_BITS - 1)) begin
            dig   <= DIG_W'(bcd_next) << (DIG_W - BCD_W);
            nd    <= NDIG_W'(BCD_DIGITS);
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (nib == 4'd0 && nd > NDIG_W'(1)) begin
            dig <= dig << 4;
            nd  <= nd - 1'b1;
          end else begin
            len   <= nil ? NIL_LEN : prefix + LEN_W'(nd);
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            m_axis_tdata  <= OUT_DATA_W'({len, ch});
            m_axis_tlast  <= (pos == len - 1'b1);
            pos           <= pos + 1'b1;
            if (is_digit && !nil) begin
              dig <= dig << 4;
            end
            if (pos == len - 1'b1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> pos < len)
    else $error("emit position beyond run length");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> len >= 5'd1 && len <= 5'd18)
    else $error("run length out of range");

  a_skip_nd: assert property (@(posedge clk) disable iff (rst)
    state == ST_SKIP |-> nd >= NDIG_W'(1))
    else $error("digit count fell to zero");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a character run");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for integer_to_ascii_formatter: formats, extremes and random numbers.
// A local formatter predicts each character beat. Needs i2a_pkg and the top-level RTL.
`timescale 1ns / 100ps

module tb;
  import i2a_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int SQUEEZE_LEN  = 400;
  localparam int SQUEEZE_AT   = 50;
  localparam int RANDOM_ITEMS = 70;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [FUNC_W-1:0] fmt;
    logic [63:0]       num;
  } num_req_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              last;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [FUNC_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  num_req_t   pend_q[$];
  char_beat_t text_q[$];

  int  errors      = 0;
  int  beats_in    = 0;
  int  idle_cycles = 0;
  int  cyc         = 0;
  bit  calm        = 1'b0;
  bit  in_taken    = 1'b0;
  int  tx_gap      = 0;
  int  rx_stall    = 0;
  int  rx_hold     = 0;
  bit  squeeze_done = 1'b0;

  integer_to_ascii_formatter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] pick_number();
    logic [63:0] full;
    full = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return full;
      1: return full >> $urandom_range(0, 63);
      2: return 64'($urandom_range(0, 20));
      3: return 64'h1 << $urandom_range(0, 63);
      4: return ~64'h0 >> $urandom_range(0, 63);
      default: begin
        if ($urandom_range(0, 1) == 0) return {full[63:32], 32'h8000_0000 + $urandom_range(0, 9)};
        return {full[63:32], 32'hFFFF_FFFF - $urandom_range(0, 9)};
      end
    endcase
  endfunction

  // Queues the character beats that one number produces.
  function automatic void format_number(input logic [FUNC_W-1:0] fmt, input logic [63:0] num);
    logic [CHAR_W-1:0] txt[$];
    logic [CHAR_W-1:0] digs[$];
    logic [31:0]       low;
    logic [63:0]       mag;
    logic [63:0]       radix;
    logic [CHAR_W-1:0] d;
    bit                upper;
    bit                nil;
    string             nil_txt;
    char_beat_t        b;
    nil_txt = "(nil)";
    low     = num[31:0];
    upper   = 1'b0;
    nil     = 1'b0;
    radix   = 64'd16;
    mag     = num;
    case (fmt)
      FMT_SDEC: begin
        radix = 64'd10;
        if (low[31]) begin
          txt.push_back(ASC_MINUS);
          mag = {32'h0, -low};
        end else begin
          mag = {32'h0, low};
        end
      end
      FMT_UDEC: begin
        radix = 64'd10;
        mag   = {32'h0, low};
      end
      FMT_HEXL: ;
      FMT_HEXU: upper = 1'b1;
      FMT_PTR: begin
        if (num == 64'h0) begin
          nil = 1'b1;
          for (int i = 0; i < 5; i++) txt.push_back(nil_txt[i]);
        end else begin
          txt.push_back(ASC_ZERO);
          txt.push_back(ASC_X);
        end
      end
      default: return;
    endcase
    if (!nil) begin
      do begin
        d   = CHAR_W'(mag % radix);
        mag = mag / radix;
        if (d < 10) digs.push_front(ASC_ZERO + d);
        else        digs.push_front((upper ? ASC_UOFS : ASC_LOFS) + d);
      end while (mag != 0);
      foreach (digs[i]) txt.push_back(digs[i]);
    end
    foreach (txt[i]) begin
      b.ch   = txt[i];
      b.len  = LEN_W'(txt.size());
      b.last = (i == txt.size() - 1);
      text_q.push_back(b);
    end
  endfunction

  function automatic void add_req(input logic [FUNC_W-1:0] fmt, input logic [63:0] num);
    num_req_t r;
    r.fmt = fmt;
    r.num = num;
    pend_q.push_back(r);
  endfunction

  // input and output beats, prediction and checking
  always @(posedge clk) begin
    char_beat_t want;
    char_beat_t got;
    cyc <= cyc + 1;
    if (cyc % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        format_number(s_axis_tuser, s_axis_tdata);
        beats_in <= beats_in + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.ch   = m_axis_tdata[7:0];
        got.len  = m_axis_tdata[12:8];
        got.last = m_axis_tlast;
        if (text_q.size() == 0) begin
          $display("%0t: unexpected beat char %h len %0d last %0b",
                   $time, got.ch, got.len, got.last);
          errors <= errors + 1;
        end else begin
          want = text_q.pop_front();
          if (got.ch != want.ch || got.len != want.len || got.last != want.last) begin
            $display("%0t: expected char %h len %0d last %0b, got char %h len %0d last %0b",
                     $time, want.ch, want.len, want.last, got.ch, got.len, got.last);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // sender
  always @(negedge clk) begin
    num_req_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        r = pend_q.pop_front();
        s_axis_tdata  <= r.num;
        s_axis_tuser  <= r.fmt;
        s_axis_tvalid <= 1'b1;
        tx_gap <= gap_len(calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off while the sender keeps offering
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!squeeze_done && beats_in >= SQUEEZE_AT) begin
      rx_hold <= SQUEEZE_LEN;
      squeeze_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) rx_stall <= gap_len(1'b0);
    end
  end

  initial begin
    int n;
    logic [FUNC_W-1:0] f;
    add_req(FMT_SDEC, 64'h0);
    add_req(FMT_SDEC, 64'h1);
    add_req(FMT_SDEC, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(FMT_SDEC, 64'h0000_0000_8000_0000);
    add_req(FMT_SDEC, 64'hDEAD_BEEF_7FFF_FFFF);
    add_req(FMT_UDEC, 64'h0);
    add_req(FMT_UDEC, 64'h0000_0000_FFFF_FFFF);
    add_req(FMT_UDEC, 64'hFFFF_FFFF_4996_02D2);
    add_req(FMT_HEXL, 64'h0);
    add_req(FMT_HEXL, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(FMT_HEXL, 64'h0123_4567_89AB_CDEF);
    add_req(FMT_HEXU, 64'h0);
    add_req(FMT_HEXU, 64'hFEDC_BA98_7654_3210);
    add_req(FMT_HEXU, 64'hA);
    add_req(FMT_PTR,  64'h0);
    add_req(FMT_PTR,  64'h1);
    add_req(FMT_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
    add_req(FMT_PTR,  64'hFFFF_FFFF_0000_0000);
    add_req(3'd5, 64'h1234);
    add_req(3'd6, 64'h0);
    add_req(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(FMT_HEXL, 64'h8000_0000_0000_0000);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        f = FUNC_W'($urandom_range(5, 7));
      end else begin
        f = FUNC_W'($urandom_range(0, 4));
        n++;
      end
      add_req(f, pick_number());
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pend_q.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (text_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && text_q.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
